[design/memory_map_classify_merge_top_defines.svh]
// Assertion macros shared by the memory map merge design files.
// Each user module must provide clk and arst_n in its scope.
`ifndef MEMORY_MAP_CLASSIFY_MERGE_TOP_DEFINES_SVH
`define MEMORY_MAP_CLASSIFY_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMCM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mmcm_pkg.sv]
// Types, constants and the firmware type classifier for the memory map merge block.
// No dependencies; used by mmcm_merge and memory_map_classify_merge_top.
package mmcm_pkg;

	localparam int ADDR_W  = 64;
	localparam int PAGES_W = 52;
	localparam int ATTR_W  = 32;
	localparam int FW_W    = 32;
	localparam int INDEX_W = 16;

	// Firmware memory type codes.
	localparam logic [FW_W-1:0] FW_RESERVED     = 32'd0;
	localparam logic [FW_W-1:0] FW_LOADER_CODE  = 32'd1;
	localparam logic [FW_W-1:0] FW_LOADER_DATA  = 32'd2;
	localparam logic [FW_W-1:0] FW_BOOT_CODE    = 32'd3;
	localparam logic [FW_W-1:0] FW_BOOT_DATA    = 32'd4;
	localparam logic [FW_W-1:0] FW_RT_CODE      = 32'd5;
	localparam logic [FW_W-1:0] FW_RT_DATA      = 32'd6;
	localparam logic [FW_W-1:0] FW_CONVENTIONAL = 32'd7;
	localparam logic [FW_W-1:0] FW_UNUSABLE     = 32'd8;
	localparam logic [FW_W-1:0] FW_ACPI_RECLAIM = 32'd9;
	localparam logic [FW_W-1:0] FW_ACPI_NVS     = 32'd10;
	localparam logic [FW_W-1:0] FW_MMIO         = 32'd11;
	localparam logic [FW_W-1:0] FW_MMIO_PORT    = 32'd12;
	localparam logic [FW_W-1:0] FW_PAL_CODE     = 32'd13;
	localparam logic [FW_W-1:0] FW_PERSISTENT   = 32'd14;

	localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};
	localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_REGION = 2'd0,
		KIND_FINAL  = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RT_FREE    = 3'd0,
		RT_PENDING = 3'd1,
		RT_ACPI    = 3'd2,
		RT_RUNTIME = 3'd3,
		RT_MMIO    = 3'd4,
		RT_PERSIST = 3'd5
	} rtype_t;

	typedef struct packed {
		logic               req_type;
		logic [FW_W-1:0]    fw_type;
		logic [ADDR_W-1:0]  phys_start;
		logic [PAGES_W-1:0] page_total;
		logic [ATTR_W-1:0]  attr_low;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  start;
		logic [PAGES_W-1:0] pages;
		rtype_t             rtype;
		logic [ATTR_W-1:0]  attr;
		logic [INDEX_W-1:0] index;
	} result_t;

	typedef struct packed {
		logic   bad;
		logic   drop;
		rtype_t rtype;
	} class_t;

	// Map a firmware type code to a kernel region type, a drop or an error.
	function automatic class_t mmcm_classify(input logic [FW_W-1:0] code);
		class_t c;
		c = '{bad: 1'b0, drop: 1'b0, rtype: RT_FREE};
		unique case (code)
			FW_RESERVED, FW_UNUSABLE, FW_ACPI_NVS, FW_PAL_CODE: c.drop = 1'b1;
			FW_LOADER_CODE, FW_LOADER_DATA, FW_BOOT_CODE, FW_BOOT_DATA,
			FW_CONVENTIONAL: c.rtype = RT_FREE;
			FW_RT_CODE, FW_RT_DATA: c.rtype = RT_RUNTIME;
			FW_ACPI_RECLAIM: c.rtype = RT_ACPI;
			FW_MMIO, FW_MMIO_PORT: c.rtype = RT_MMIO;
			FW_PERSISTENT: c.rtype = RT_PERSIST;
			default: c.bad = 1'b1;
		endcase
		return c;
	endfunction

endpackage

[design/mmcm_merge.sv]
// Pending region state and the per-item classify and merge decision.
// Depends on mmcm_pkg and the assertion macros header.
`include "memory_map_classify_merge_top_defines.svh"

module mmcm_merge #(
	parameter int PAGE_SHIFT = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  mmcm_pkg::item_t  item,
	output logic             emit,
	output mmcm_pkg::result_t result
);
	import mmcm_pkg::*;

	localparam int WIDE_W = PAGES_W + PAGE_SHIFT;

	logic               have_pending_q;
	logic [ADDR_W-1:0]  pend_start_q;
	logic [PAGES_W-1:0] pend_pages_q;
	rtype_t             pend_kind_q;
	logic [ATTR_W-1:0]  pend_attr_q;
	logic [INDEX_W-1:0] emitted_count_q;

	class_t             cls;
	logic [WIDE_W-1:0]  pend_bytes;
	logic [WIDE_W:0]    pend_end;
	logic               adjoins;
	logic [PAGES_W:0]   page_sum;
	logic               same_region;

	logic               clear_state;
	logic               load_pend;
	logic               grow_pend;
	logic               bump_count;

	// End of the pending region, widened so that any overflow shows in the top bits.
	assign cls        = mmcm_classify(item.fw_type);
	assign pend_bytes = WIDE_W'(pend_pages_q) << PAGE_SHIFT;
	assign pend_end   = (WIDE_W+1)'(pend_start_q) + (WIDE_W+1)'(pend_bytes);
	assign adjoins    = (pend_end[WIDE_W:ADDR_W] == '0) &&
	                    (pend_end[ADDR_W-1:0] == item.phys_start);
	assign page_sum   = (PAGES_W+1)'(pend_pages_q) + (PAGES_W+1)'(item.page_total);
	assign same_region = (pend_kind_q == cls.rtype) && (pend_attr_q == item.attr_low) &&
	                     adjoins;

	// Decide what this item does to the state and what result it produces.
	always_comb begin
		emit        = 1'b0;
		clear_state = 1'b0;
		load_pend   = 1'b0;
		grow_pend   = 1'b0;
		bump_count  = 1'b0;
		result      = '{kind: KIND_REGION, start: pend_start_q, pages: pend_pages_q,
		                rtype: pend_kind_q, attr: pend_attr_q, index: emitted_count_q};
		priority if (item.req_type) begin
			emit        = 1'b1;
			clear_state = 1'b1;
			if (have_pending_q) begin
				result.kind = KIND_FINAL;
			end else begin
				result = '{kind: KIND_EMPTY, start: '0, pages: '0, rtype: RT_FREE,
				           attr: '0, index: '0};
			end
		end else if (cls.bad) begin
			emit   = 1'b1;
			result = '{kind: KIND_BAD, start: item.phys_start, pages: item.page_total,
			           rtype: RT_FREE, attr: item.attr_low, index: '0};
		end else if (cls.drop) begin
			emit = 1'b0;
		end else if (!have_pending_q) begin
			load_pend = 1'b1;
		end else if (same_region) begin
			grow_pend = 1'b1;
		end else begin
			emit       = 1'b1;
			load_pend  = 1'b1;
			bump_count = 1'b1;
		end
	end

	// Control state: pending flag and emitted region count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pending_q  <= 1'b0;
			emitted_count_q <= '0;
		end else if (step) begin
			if (clear_state) begin
				have_pending_q  <= 1'b0;
				emitted_count_q <= '0;
			end else begin
				if (load_pend) begin
					have_pending_q <= 1'b1;
				end
				if (bump_count && emitted_count_q != INDEX_MAX) begin
					emitted_count_q <= emitted_count_q + INDEX_W'(1);
				end
			end
		end
	end

	// Pending region payload; only read while the pending flag is set.
	always_ff @(posedge clk) begin
		if (step && load_pend) begin
			pend_start_q <= item.phys_start;
			pend_pages_q <= item.page_total;
			pend_kind_q  <= cls.rtype;
			pend_attr_q  <= item.attr_low;
		end else if (step && grow_pend) begin
			pend_pages_q <= page_sum[PAGES_W] ? PAGES_MAX : page_sum[PAGES_W-1:0];
		end
	end

	`MMCM_ASSERT_NEXT(a_end_clears, step && item.req_type, !have_pending_q && emitted_count_q == '0, "end item did not clear the pending state")
	`MMCM_ASSERT_IMPL(a_grow_needs_pend, step && grow_pend, have_pending_q && !emit, "merge without a pending region")
	`MMCM_ASSERT_IMPL(a_final_needs_pend, emit && result.kind == KIND_FINAL, have_pending_q, "final region without a pending region")

endmodule

[design/memory_map_classify_merge_top.sv]
// Top level of the memory map classify and merge block: input stage and result register.
// Depends on mmcm_pkg, mmcm_merge and the assertion macros header.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one descriptor or end-of-map item.
//   Output channel (out_valid / out_stall) carries at most one result item per input.
//   An item is taken at a clock edge with valid high and stall low.
// Timing:
//   An item is registered in the input stage at the edge it is accepted and decided there,
//   against the pending region, with one widened end-address add and a 64-bit compare.
//   A result is registered in the result register when its item leaves the input stage.
//   Throughput is one item per cycle while the output is not stalled.
// Stalls:
//   The result register holds a valid result while out_stall is high. An item that would produce a
//   result then waits in the input stage, and in_stall rises; items that produce no
//   result still pass through and update the pending region.
// Reset:
//   arst_n clears the pending region, the region count and both stage valids.
//   An end-of-map item also returns the state to its reset condition.
`include "memory_map_classify_merge_top_defines.svh"

module memory_map_classify_merge_top #(
	parameter int PAGE_SHIFT = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [mmcm_pkg::FW_W-1:0]       fw_type,
	input  logic [mmcm_pkg::ADDR_W-1:0]     phys_start,
	input  logic [mmcm_pkg::PAGES_W-1:0]    page_total,
	input  logic [mmcm_pkg::ATTR_W-1:0]     attr_low,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      result_kind,
	output logic [mmcm_pkg::ADDR_W-1:0]     region_start,
	output logic [mmcm_pkg::PAGES_W-1:0]    region_pages,
	output logic [2:0]                      region_type,
	output logic [mmcm_pkg::ATTR_W-1:0]     region_attr,
	output logic [mmcm_pkg::INDEX_W-1:0]    region_index
);
	import mmcm_pkg::*;

	logic    s1_valid_q;
	item_t   item_s1;
	logic    emit;
	result_t result;
	logic    out_valid_q;
	result_t out_q;
	logic    out_free;
	logic    s1_adv;
	logic    in_take;

	// Handshake between the stages.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && (!emit || out_free);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{req_type: req_type, fw_type: fw_type, phys_start: phys_start,
			             page_total: page_total, attr_low: attr_low};
		end
	end

	// Classify and merge against the pending region.
	mmcm_merge #(
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_adv),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign region_start = out_q.start;
	assign region_pages = out_q.pages;
	assign region_type  = out_q.rtype;
	assign region_attr  = out_q.attr;
	assign region_index = out_q.index;

	`MMCM_ASSERT_NEXT(a_emit_waits, s1_valid_q && emit && out_valid_q && out_stall, s1_valid_q, "input stage dropped an item while the result register was full")
	`MMCM_ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid_q, "input stalled with an empty stage")
	`MMCM_ASSERT_IMPL(a_empty_zero, out_valid_q && out_q.kind == KIND_EMPTY, out_q.pages == '0 && out_q.index == '0 && out_q.start == '0, "empty map result carries nonzero fields")
	`MMCM_ASSERT_IMPL(a_no_pending_type, out_valid_q, out_q.rtype != RT_PENDING, "result carries the pending region type")

endmodule
